/* rtl/core/mce_pkg.sv */
// Shared types, constants and helper functions for the matrix command engine.
package mce_pkg;

   localparam int MAX_DIM    = 8;
   localparam int SLOT_COUNT = 8;
   localparam int FRAC_BITS  = 16;

   localparam int DATA_W     = 32;
   localparam int OP_W       = 4;
   localparam int DIM_W      = 4;
   localparam int SLOT_W     = 3;
   localparam int STATUS_W   = 3;
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int CELLS      = MAX_DIM * MAX_DIM;
   localparam int CELL_W     = $clog2(CELLS);
   localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = PROD_W + $clog2(MAX_DIM) + 1;
   localparam int SIZE_W     = 2 * DIM_W;

   localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

   typedef enum logic [OP_W-1:0] {
      OP_SET    = 4'd0,
      OP_FILL   = 4'd1,
      OP_RESIZE = 4'd2,
      OP_SCALE  = 4'd3,
      OP_SAVE   = 4'd4,
      OP_LOAD   = 4'd5,
      OP_MUL    = 4'd6,
      OP_ADD    = 4'd7,
      OP_SUB    = 4'd8,
      OP_TRANS  = 4'd9,
      OP_IDENT  = 4'd10,
      OP_READ   = 4'd11
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK         = 3'd0,
      STS_BOUNDS     = 3'd1,
      STS_EMPTY      = 3'd2,
      STS_MISMATCH   = 3'd3,
      STS_NOT_SQUARE = 3'd4,
      STS_BAD_SIZE   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      PK_FILL,
      PK_IDENT,
      PK_SCALE,
      PK_ADD,
      PK_SUB,
      PK_SAVE,
      PK_LOAD,
      PK_TRANS,
      PK_MUL,
      PK_COPY,
      PK_SET,
      PK_READ
   } pass_type;

   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_RESIZE,
      UPD_LOAD,
      UPD_SAVE,
      UPD_MUL,
      UPD_SWAP
   } upd_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_START_A,
      CS_WAIT_A,
      CS_START_B,
      CS_WAIT_B,
      CS_RESP
   } ctl_state_type;

   typedef struct packed {
      logic                      start;
      logic                      clear;
      pass_type                  kind;
      upd_type                   upd;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic [SLOT_W-1:0]         slot;
      logic signed [DATA_W-1:0]  operand;
      logic [DIM_W-1:0]          resize_rows;
      logic [DIM_W-1:0]          resize_cols;
   } dp_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              sel_valid;
      logic [DIM_W-1:0]  sel_rows;
      logic [DIM_W-1:0]  sel_cols;
      logic [DIM_W-1:0]  dim_rows;
      logic [DIM_W-1:0]  dim_cols;
   } dp_stat_type;

   function automatic logic [CELL_W-1:0] flat_addr(input logic [IDX_W-1:0] r,
                                                   input logic [DIM_W-1:0] stride,
                                                   input logic [IDX_W-1:0] c);
      logic [IDX_W+DIM_W:0] sum;
      sum = (IDX_W+DIM_W+1)'(r * stride) + (IDX_W+DIM_W+1)'(c);
      return sum[CELL_W-1:0];
   endfunction

   // {saturated, value}
   function automatic logic [DATA_W:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, v[DATA_W-1:0]};
      end
   endfunction

endpackage

/* rtl/core/mce_req_if.sv */
// Command channel: valid/ready with one command per beat.
interface mce_req_if;
   import mce_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           opcode;
   logic [IDX_W-1:0]          row_index;
   logic [IDX_W-1:0]          col_index;
   logic signed [DATA_W-1:0]  operand_value;
   logic [SLOT_W-1:0]         slot_number;
   logic [DIM_W-1:0]          resize_rows;
   logic [DIM_W-1:0]          resize_cols;

   modport source (output valid, opcode, row_index, col_index, operand_value, slot_number,
                   resize_rows, resize_cols, input ready);
   modport sink   (input valid, opcode, row_index, col_index, operand_value, slot_number,
                   resize_rows, resize_cols, output ready);
endinterface

/* rtl/core/mce_rsp_if.sv */
// Response channel: valid/ready with one status beat per command.
interface mce_rsp_if;
   import mce_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic                      overflow;
   logic signed [DATA_W-1:0]  read_value;
   logic [DIM_W-1:0]          current_rows;
   logic [DIM_W-1:0]          current_cols;

   modport source (output valid, status, overflow, read_value, current_rows, current_cols,
                   input ready);
   modport sink   (input valid, status, overflow, read_value, current_rows, current_cols,
                   output ready);
endinterface

/* rtl/core/matrix_command_engine.sv */
// Matrix command engine top level: controller plus matrix datapath.
//
// One command is taken at a time and answered by exactly one status beat.
// Multiply computes an m x n slot times the current n x k matrix; transpose and
// multiply write a scratch store and then copy it back in a second pass. Sweep
// speed is set by the single 32x32 multiply-accumulate unit, which takes one
// product per cycle, and by the one read port of each store, which moves one
// element per cycle. Resize and failed commands run no sweep.
// Reset leaves a 1x1 zero matrix and no saved slots; no clearing pass is
// needed.
module matrix_command_engine (
   input  logic   clock,
   input  logic   reset,
   mce_req_if.sink   req_chan,
   mce_rsp_if.source rsp_chan
);
   import mce_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   mce_controller u_ctl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_opcode      (req_chan.opcode),
      .req_row         (req_chan.row_index),
      .req_col         (req_chan.col_index),
      .req_operand     (req_chan.operand_value),
      .req_slot        (req_chan.slot_number),
      .req_resize_rows (req_chan.resize_rows),
      .req_resize_cols (req_chan.resize_cols),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .cmd             (cmd),
      .stat            (stat)
   );

   mce_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .overflow   (rsp_chan.overflow),
      .read_value (rsp_chan.read_value)
   );

   assign rsp_chan.current_rows = stat.dim_rows;
   assign rsp_chan.current_cols = stat.dim_cols;

endmodule

/* rtl/core/mce_datapath.sv */
// Matrix stores, sweep address generator and three-stage MAC/saturate pipeline.
module mce_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  mce_pkg::dp_cmd_type          cmd,
   output mce_pkg::dp_stat_type         stat,
   output logic                         overflow,
   output logic signed [mce_pkg::DATA_W-1:0] read_value
);
   import mce_pkg::*;

   // dimensions and slot bookkeeping
   logic [DIM_W-1:0]      dim_rows_ff, dim_cols_ff;
   logic [DIM_W-1:0]      slot_rows_ff [SLOT_COUNT];
   logic [DIM_W-1:0]      slot_cols_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] slot_valid_ff;
   logic [CELLS-1:0]      cur_valid_ff;

   // memories
   logic [DATA_W-1:0] cur_mem  [CELLS];
   logic [DATA_W-1:0] scr_mem  [CELLS];
   logic [DATA_W-1:0] slot_mem [SLOT_COUNT*CELLS];

   // sweep
   logic              active_ff;
   pass_type          kind_ff;
   logic [IDX_W-1:0]  i_ff, j_ff, p_ff;
   logic [DIM_W-1:0]  bi_ff, bj_ff, bp_ff;

   // stage 1
   logic              v1_ff, first1_ff, last1_ff, diag1_ff;
   logic [CELL_W-1:0] wa1_ff;
   logic [DATA_W-1:0] cur_rd_ff, slot_rd_ff, scr_rd_ff;
   logic              cur_rdv_ff;

   // stage 2
   logic                     v2_ff, first2_ff, last2_ff, diag2_ff;
   logic [CELL_W-1:0]        wa2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] a2_ff, b2_ff, s2_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic                     ovf_ff;
   logic signed [DATA_W-1:0] rdval_ff;

   logic [SLOT_IDX_W-1:0] sidx;
   logic [DIM_W-1:0]      sel_rows, sel_cols;
   logic                  i_last, j_last, p_last;
   logic [CELL_W-1:0]     ra_cur, ra_slot_cell, ra_scr, wa0;
   logic [IDX_W-1:0]      idx_mul_i, idx_slot_j;
   logic signed [DATA_W-1:0] a1, x1;

   logic signed [ACC_W-1:0] acc_sum, acc_shift, addsub;
   logic [DATA_W:0]         sat_mul, sat_as;
   logic [DATA_W-1:0]       wdata;
   logic                    cur_we, scr_we, slot_we, rd_we, ovf_hit;
   logic [SIZE_W-1:0]       size_old, size_new;

   assign sidx     = cmd.slot[SLOT_IDX_W-1:0];
   assign sel_rows = slot_rows_ff[sidx];
   assign sel_cols = slot_cols_ff[sidx];

   assign stat.busy      = active_ff | v1_ff | v2_ff;
   assign stat.sel_valid = slot_valid_ff[sidx];
   assign stat.sel_rows  = sel_rows;
   assign stat.sel_cols  = sel_cols;
   assign stat.dim_rows  = dim_rows_ff;
   assign stat.dim_cols  = dim_cols_ff;

   assign overflow   = ovf_ff;
   assign read_value = rdval_ff;

   // issue stage addressing
   assign i_last = (i_ff == IDX_W'(bi_ff - DIM_W'(1)));
   assign j_last = (j_ff == IDX_W'(bj_ff - DIM_W'(1)));
   assign p_last = (p_ff == IDX_W'(bp_ff - DIM_W'(1)));

   assign idx_mul_i    = (kind_ff == PK_MUL) ? p_ff : i_ff;
   assign idx_slot_j   = (kind_ff == PK_MUL) ? p_ff : j_ff;
   assign ra_cur       = flat_addr(idx_mul_i, dim_cols_ff, j_ff);
   assign ra_slot_cell = flat_addr(i_ff, sel_cols, idx_slot_j);
   assign ra_scr       = flat_addr(i_ff, dim_cols_ff, j_ff);
   assign wa0          = (kind_ff == PK_TRANS) ? flat_addr(j_ff, dim_rows_ff, i_ff)
                                               : flat_addr(i_ff, dim_cols_ff, j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (cmd.start) begin
         active_ff <= 1'b1;
      end else if (active_ff && i_last && j_last && p_last) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff <= cmd.kind;
         p_ff    <= '0;
         bp_ff   <= (cmd.kind == PK_MUL) ? sel_cols : DIM_W'(1);
         if (cmd.kind == PK_SET || cmd.kind == PK_READ) begin
            i_ff  <= cmd.row;
            j_ff  <= cmd.col;
            bi_ff <= DIM_W'(cmd.row) + DIM_W'(1);
            bj_ff <= DIM_W'(cmd.col) + DIM_W'(1);
         end else begin
            i_ff  <= '0;
            j_ff  <= '0;
            bi_ff <= (cmd.kind == PK_MUL) ? sel_rows : dim_rows_ff;
            bj_ff <= dim_cols_ff;
         end
      end else if (active_ff) begin
         if (p_last) begin
            p_ff <= '0;
            if (j_last) begin
               j_ff <= '0;
               i_ff <= i_ff + IDX_W'(1);
            end else begin
               j_ff <= j_ff + IDX_W'(1);
            end
         end else begin
            p_ff <= p_ff + IDX_W'(1);
         end
      end
   end

   // stage 1: registered memory reads
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= active_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff  <= (p_ff == '0);
      last1_ff   <= p_last;
      diag1_ff   <= (i_ff == j_ff);
      wa1_ff     <= wa0;
      cur_rdv_ff <= cur_valid_ff[ra_cur];
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[wa2_ff] <= wdata;
      end
      cur_rd_ff <= cur_mem[ra_cur];
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[wa2_ff] <= wdata;
      end
      scr_rd_ff <= scr_mem[ra_scr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[{sidx, wa2_ff}] <= wdata;
      end
      slot_rd_ff <= slot_mem[{sidx, ra_slot_cell}];
   end

   // stage 2: multiply
   assign a1 = cur_rdv_ff ? signed'(cur_rd_ff) : '0;
   assign x1 = (kind_ff == PK_MUL) ? signed'(slot_rd_ff) : cmd.operand;

   always_ff @(posedge clock) begin
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      diag2_ff  <= diag1_ff;
      wa2_ff    <= wa1_ff;
      prod_ff   <= x1 * a1;
      a2_ff     <= a1;
      b2_ff     <= signed'(slot_rd_ff);
      s2_ff     <= signed'(scr_rd_ff);
   end

   // stage 3: accumulate, shift, saturate, write back
   assign acc_sum   = (first2_ff ? '0 : acc_ff)
                      + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_shift = acc_sum >>> FRAC_BITS;
   assign addsub    = (kind_ff == PK_SUB)
                      ? ACC_W'(a2_ff) - ACC_W'(b2_ff)
                      : ACC_W'(a2_ff) + ACC_W'(b2_ff);
   assign sat_mul   = sat_acc(acc_shift);
   assign sat_as    = sat_acc(addsub);

   always_comb begin
      wdata   = '0;
      cur_we  = 1'b0;
      scr_we  = 1'b0;
      slot_we = 1'b0;
      rd_we   = 1'b0;
      ovf_hit = 1'b0;
      unique case (kind_ff)
         PK_FILL, PK_SET: begin
            wdata  = cmd.operand;
            cur_we = v2_ff;
         end
         PK_IDENT: begin
            wdata  = diag2_ff ? FX_ONE : '0;
            cur_we = v2_ff;
         end
         PK_SCALE: begin
            wdata   = sat_mul[DATA_W-1:0];
            cur_we  = v2_ff;
            ovf_hit = v2_ff & sat_mul[DATA_W];
         end
         PK_ADD, PK_SUB: begin
            wdata   = sat_as[DATA_W-1:0];
            cur_we  = v2_ff;
            ovf_hit = v2_ff & sat_as[DATA_W];
         end
         PK_SAVE: begin
            wdata   = a2_ff;
            slot_we = v2_ff;
         end
         PK_LOAD: begin
            wdata  = b2_ff;
            cur_we = v2_ff;
         end
         PK_TRANS: begin
            wdata  = a2_ff;
            scr_we = v2_ff;
         end
         PK_MUL: begin
            wdata   = sat_mul[DATA_W-1:0];
            scr_we  = v2_ff & last2_ff;
            ovf_hit = v2_ff & last2_ff & sat_mul[DATA_W];
         end
         PK_COPY: begin
            wdata  = s2_ff;
            cur_we = v2_ff;
         end
         PK_READ: begin
            wdata = a2_ff;
            rd_we = v2_ff;
         end
         default: begin
            wdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         acc_ff <= acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff   <= 1'b0;
         rdval_ff <= '0;
      end else if (cmd.clear) begin
         ovf_ff   <= 1'b0;
         rdval_ff <= '0;
      end else begin
         if (ovf_hit) begin
            ovf_ff <= 1'b1;
         end
         if (rd_we) begin
            rdval_ff <= wdata;
         end
      end
   end

   // dimension and slot updates
   assign size_old = SIZE_W'(dim_rows_ff * dim_cols_ff);
   assign size_new = SIZE_W'(cmd.resize_rows * cmd.resize_cols);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_rows_ff   <= DIM_W'(1);
         dim_cols_ff   <= DIM_W'(1);
         slot_valid_ff <= '0;
      end else begin
         unique case (cmd.upd)
            UPD_RESIZE: begin
               dim_rows_ff <= cmd.resize_rows;
               dim_cols_ff <= cmd.resize_cols;
            end
            UPD_LOAD: begin
               dim_rows_ff <= sel_rows;
               dim_cols_ff <= sel_cols;
            end
            UPD_SAVE: begin
               slot_valid_ff[sidx] <= 1'b1;
            end
            UPD_MUL: begin
               dim_rows_ff <= sel_rows;
            end
            UPD_SWAP: begin
               dim_rows_ff <= dim_cols_ff;
               dim_cols_ff <= dim_rows_ff;
            end
            default: begin
               dim_rows_ff <= dim_rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd == UPD_SAVE) begin
         slot_rows_ff[sidx] <= dim_rows_ff;
         slot_cols_ff[sidx] <= dim_cols_ff;
      end
   end

   // an entry with a clear valid bit reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= '0;
      end else if (cmd.upd == UPD_RESIZE) begin
         for (int f = 0; f < CELLS; f++) begin
            if (SIZE_W'(f) >= size_old && SIZE_W'(f) < size_new) begin
               cur_valid_ff[f] <= 1'b0;
            end
         end
      end else if (cur_we) begin
         cur_valid_ff[wa2_ff] <= 1'b1;
      end
   end

endmodule

/* rtl/core/mce_controller.sv */
// Command controller: accepts a command, checks it, sequences datapath passes, returns status.
module mce_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mce_pkg::OP_W-1:0]      req_opcode,
   input  logic [mce_pkg::IDX_W-1:0]     req_row,
   input  logic [mce_pkg::IDX_W-1:0]     req_col,
   input  logic signed [mce_pkg::DATA_W-1:0] req_operand,
   input  logic [mce_pkg::SLOT_W-1:0]    req_slot,
   input  logic [mce_pkg::DIM_W-1:0]     req_resize_rows,
   input  logic [mce_pkg::DIM_W-1:0]     req_resize_cols,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mce_pkg::STATUS_W-1:0]  rsp_status,
   output mce_pkg::dp_cmd_type           cmd,
   input  mce_pkg::dp_stat_type          stat
);
   import mce_pkg::*;

   ctl_state_type state_ff, state_in;
   status_type    status_ff, status_in;
   pass_type      pass_ff, pass_in;
   logic          copy_ff, copy_in;

   logic [OP_W-1:0]          opcode_ff;
   logic [IDX_W-1:0]         row_ff, col_ff;
   logic signed [DATA_W-1:0] operand_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [DIM_W-1:0]         resize_rows_ff, resize_cols_ff;

   logic slot_in_range;

   assign slot_in_range = (32'(slot_ff) < 32'(SLOT_COUNT));
   assign rsp_status    = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CS_IDLE;
         status_ff <= STS_OK;
         pass_ff   <= PK_FILL;
         copy_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         pass_ff   <= pass_in;
         copy_ff   <= copy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == CS_IDLE && req_valid) begin
         opcode_ff      <= req_opcode;
         row_ff         <= req_row;
         col_ff         <= req_col;
         operand_ff     <= req_operand;
         slot_ff        <= req_slot;
         resize_rows_ff <= req_resize_rows;
         resize_cols_ff <= req_resize_cols;
      end
   end

   always_comb begin
      logic       run;
      status_type sts;
      state_in        = state_ff;
      status_in       = status_ff;
      pass_in         = pass_ff;
      copy_in         = copy_ff;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      run             = 1'b0;
      sts             = STS_OK;
      cmd             = '0;
      cmd.kind        = pass_ff;
      cmd.upd         = UPD_NONE;
      cmd.row         = row_ff;
      cmd.col         = col_ff;
      cmd.slot        = slot_ff;
      cmd.operand     = operand_ff;
      cmd.resize_rows = resize_rows_ff;
      cmd.resize_cols = resize_cols_ff;

      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = CS_DECODE;
            end
         end
         CS_DECODE: begin
            cmd.clear = 1'b1;
            copy_in   = 1'b0;
            unique case (op_type'(opcode_ff))
               OP_SET, OP_READ: begin
                  if (DIM_W'(row_ff) >= stat.dim_rows || DIM_W'(col_ff) >= stat.dim_cols) begin
                     sts = STS_BOUNDS;
                  end else begin
                     run     = 1'b1;
                     pass_in = (op_type'(opcode_ff) == OP_SET) ? PK_SET : PK_READ;
                  end
               end
               OP_FILL: begin
                  run     = 1'b1;
                  pass_in = PK_FILL;
               end
               OP_RESIZE: begin
                  if (resize_rows_ff == '0 || 32'(resize_rows_ff) > 32'(MAX_DIM) ||
                      resize_cols_ff == '0 || 32'(resize_cols_ff) > 32'(MAX_DIM)) begin
                     sts = STS_BAD_SIZE;
                  end else begin
                     cmd.upd = UPD_RESIZE;
                  end
               end
               OP_SCALE: begin
                  run     = 1'b1;
                  pass_in = PK_SCALE;
               end
               OP_SAVE: begin
                  if (!slot_in_range) begin
                     sts = STS_BOUNDS;
                  end else begin
                     cmd.upd = UPD_SAVE;
                     run     = 1'b1;
                     pass_in = PK_SAVE;
                  end
               end
               OP_LOAD, OP_MUL, OP_ADD, OP_SUB: begin
                  if (!slot_in_range || !stat.sel_valid) begin
                     sts = STS_EMPTY;
                  end else if (op_type'(opcode_ff) == OP_LOAD) begin
                     cmd.upd = UPD_LOAD;
                     run     = 1'b1;
                     pass_in = PK_LOAD;
                  end else if (op_type'(opcode_ff) == OP_MUL) begin
                     if (stat.sel_cols != stat.dim_rows) begin
                        sts = STS_MISMATCH;
                     end else begin
                        run     = 1'b1;
                        copy_in = 1'b1;
                        pass_in = PK_MUL;
                     end
                  end else begin
                     if (stat.sel_rows != stat.dim_rows || stat.sel_cols != stat.dim_cols) begin
                        sts = STS_MISMATCH;
                     end else begin
                        run     = 1'b1;
                        pass_in = (op_type'(opcode_ff) == OP_ADD) ? PK_ADD : PK_SUB;
                     end
                  end
               end
               OP_TRANS: begin
                  run     = 1'b1;
                  copy_in = 1'b1;
                  pass_in = PK_TRANS;
               end
               OP_IDENT: begin
                  if (stat.dim_rows != stat.dim_cols) begin
                     sts = STS_NOT_SQUARE;
                  end else begin
                     run     = 1'b1;
                     pass_in = PK_IDENT;
                  end
               end
               default: begin
                  run = 1'b0;
               end
            endcase
            status_in = sts;
            state_in  = run ? CS_START_A : CS_RESP;
         end
         CS_START_A: begin
            cmd.start = 1'b1;
            state_in  = CS_WAIT_A;
         end
         CS_WAIT_A: begin
            if (!stat.busy) begin
               if (copy_ff) begin
                  cmd.upd  = (pass_ff == PK_MUL) ? UPD_MUL : UPD_SWAP;
                  state_in = CS_START_B;
               end else begin
                  state_in = CS_RESP;
               end
            end
         end
         CS_START_B: begin
            cmd.start = 1'b1;
            cmd.kind  = PK_COPY;
            state_in  = CS_WAIT_B;
         end
         CS_WAIT_B: begin
            if (!stat.busy) begin
               state_in = CS_RESP;
            end
         end
         CS_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule
